// ===== src/slr_pkg.sv =====
package slr_pkg;

	localparam int SAMPLE_W = 16;
	localparam int RATIO_W  = 20;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 20'd65536;

	typedef struct packed {
		logic load;
		logic restart;
		logic issue;
		logic finish;
		logic s1_adv;
	} cmd_t;

	typedef struct packed {
		logic ge_one;
		logic last;
	} sts_t;

endpackage

// ===== src/slr_ctrl.sv =====
module slr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          restart,
	output logic          out_valid,
	input  logic          out_ready,
	input  slr_pkg::sts_t sts,
	output slr_pkg::cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic s1_valid_q;
	logic out_valid_q;
	logic s1_adv;
	logic issue;
	logic finish;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	assign s1_adv = s1_valid_q && (!out_valid_q || out_ready);
	assign finish = (state_q == ST_RUN) && sts.ge_one;
	assign issue  = (state_q == ST_RUN) && !sts.ge_one && (!s1_valid_q || s1_adv);

	always_comb begin
		cmd.load    = in_ready && in_valid;
		cmd.restart = restart;
		cmd.issue   = issue;
		cmd.finish  = finish;
		cmd.s1_adv  = s1_adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (finish || (issue && sts.last)) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (issue) s1_valid_q <= 1'b1;
			else if (s1_adv) s1_valid_q <= 1'b0;
			if (s1_adv) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_issue_fills: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> s1_valid_q)
		else $error("issued item did not reach stage one");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !out_ready) |=> (s1_valid_q && out_valid_q))
		else $error("item dropped under stall");

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_RUN))
		else $error("accepted item did not start");

endmodule

// ===== src/slr_datapath.sv =====
module slr_datapath #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [slr_pkg::RATIO_W-1:0]          cfg_wdata,
	input  logic signed [slr_pkg::SAMPLE_W-1:0]  left_in,
	input  logic signed [slr_pkg::SAMPLE_W-1:0]  right_in,
	input  slr_pkg::cmd_t                        cmd,
	output slr_pkg::sts_t                        sts,
	output logic signed [slr_pkg::SAMPLE_W-1:0]  left_out,
	output logic signed [slr_pkg::SAMPLE_W-1:0]  right_out,
	output logic                                 last
);

	localparam int SW     = slr_pkg::SAMPLE_W;
	localparam int RW     = slr_pkg::RATIO_W;
	localparam int PW     = ((FRACTION_BITS > RW) ? FRACTION_BITS : RW) + 1;
	localparam int PROD_W = SW + 1 + FRACTION_BITS + 1;
	localparam logic [PW-1:0] PHASE_ONE = PW'(1) << FRACTION_BITS;
	localparam logic [RW-1:0] RATIO_MIN = RW'(1) << (FRACTION_BITS - 6);

	logic [RW-1:0]           ratio_q;
	logic [PW-1:0]           phase_q;
	logic signed [SW-1:0]    prev_l_q;
	logic signed [SW-1:0]    prev_r_q;
	logic signed [SW-1:0]    cur_l_q;
	logic signed [SW-1:0]    cur_r_q;

	logic [RW-1:0]           step;
	logic [PW-1:0]           phase_next;
	logic signed [SW:0]      diff_l;
	logic signed [SW:0]      diff_r;
	logic signed [FRACTION_BITS:0] frac;
	logic signed [PROD_W-1:0] prod_l;
	logic signed [PROD_W-1:0] prod_r;

	logic signed [PROD_W-1:0] prod_l_s1;
	logic signed [PROD_W-1:0] prod_r_s1;
	logic signed [SW-1:0]     base_l_s1;
	logic signed [SW-1:0]     base_r_s1;
	logic                     last_s1;

	logic signed [SW-1:0]     left_out_q;
	logic signed [SW-1:0]     right_out_q;
	logic                     last_q;

	assign step       = (ratio_q < RATIO_MIN) ? RATIO_MIN : ratio_q;
	assign phase_next = phase_q + PW'(step);
	assign sts.ge_one = (phase_q >= PHASE_ONE);
	assign sts.last   = (phase_next >= PHASE_ONE);

	assign diff_l = {cur_l_q[SW-1], cur_l_q} - {prev_l_q[SW-1], prev_l_q};
	assign diff_r = {cur_r_q[SW-1], cur_r_q} - {prev_r_q[SW-1], prev_r_q};
	assign frac   = {1'b0, phase_q[FRACTION_BITS-1:0]};
	assign prod_l = diff_l * frac;
	assign prod_r = diff_r * frac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= slr_pkg::RATIO_RESET;
			phase_q  <= '0;
			prev_l_q <= '0;
			prev_r_q <= '0;
		end else begin
			if (cfg_we) ratio_q <= cfg_wdata;
			if (cmd.load && cmd.restart) begin
				phase_q  <= '0;
				prev_l_q <= '0;
				prev_r_q <= '0;
			end else if (cmd.finish) begin
				phase_q  <= phase_q - PHASE_ONE;
				prev_l_q <= cur_l_q;
				prev_r_q <= cur_r_q;
			end else if (cmd.issue) begin
				if (sts.last) begin
					phase_q  <= phase_next - PHASE_ONE;
					prev_l_q <= cur_l_q;
					prev_r_q <= cur_r_q;
				end else begin
					phase_q <= phase_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_l_q <= left_in;
			cur_r_q <= right_in;
		end
		if (cmd.issue) begin
			prod_l_s1 <= prod_l;
			prod_r_s1 <= prod_r;
			base_l_s1 <= prev_l_q;
			base_r_s1 <= prev_r_q;
			last_s1   <= sts.last;
		end
		if (cmd.s1_adv) begin
			left_out_q  <= base_l_s1 + prod_l_s1[FRACTION_BITS +: SW];
			right_out_q <= base_r_s1 + prod_r_s1[FRACTION_BITS +: SW];
			last_q      <= last_s1;
		end
	end

	assign left_out  = left_out_q;
	assign right_out = right_out_q;
	assign last      = last_q;

endmodule

// ===== src/stereo_linear_resampler.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_ready    left_in, right_in, restart
// out       out_valid / out_ready  left_out, right_out, last
// cfg       cfg_we                 cfg_wdata (ratio, Q FRACTION_BITS)
//
// An item yields n outputs (0 to 64): it is loaded, then it either takes
// a finish step (phase already at one or more) or issues each output to the
// shared interpolation multipliers. Outputs pass a product stage and an
// output register, so the next item is taken while earlier outputs still
// drain. A stalled output holds a full product stage and further issues,
// but not a finish step. Reset clears phase, history and sets the ratio to one.
module stereo_linear_resampler #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [slr_pkg::RATIO_W-1:0]         cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [slr_pkg::SAMPLE_W-1:0] left_in,
	input  logic signed [slr_pkg::SAMPLE_W-1:0] right_in,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [slr_pkg::SAMPLE_W-1:0] left_out,
	output logic signed [slr_pkg::SAMPLE_W-1:0] right_out,
	output logic                                last
);

	slr_pkg::cmd_t cmd;
	slr_pkg::sts_t sts;

	slr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	slr_datapath #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.left_in   (left_in),
		.right_in  (right_in),
		.cmd       (cmd),
		.sts       (sts),
		.left_out  (left_out),
		.right_out (right_out),
		.last      (last)
	);

endmodule
